FILE: rtl/core/vcms_pkg.sv
// Shared constants, payload types and state encodings of the voxel statistics block.
package vcms_pkg;

    localparam int VOXEL_BITS      = 8;
    localparam int COUNT_LOG2      = 24;
    localparam int RATIO_FRAC_BITS = 16;

    localparam int CNT_W      = COUNT_LOG2 + 1;
    localparam int DIV_W      = COUNT_LOG2 + 3;
    localparam int Q_W        = RATIO_FRAC_BITS + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = {1'b1, {COUNT_LOG2{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_REF_LOW       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REF_HIGH      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CMP_LOW       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CMP_HIGH      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_RATIOS = CFG_IDX_W'(4);

    typedef struct packed {
        logic [VOXEL_BITS-1:0] ref_low;
        logic [VOXEL_BITS-1:0] ref_high;
        logic [VOXEL_BITS-1:0] cmp_low;
        logic [VOXEL_BITS-1:0] cmp_high;
        logic                  report_ratios;
    } vcms_cfg_t;

    localparam vcms_cfg_t CFG_RESET = '{
        ref_low:       VOXEL_BITS'(0),
        ref_high:      VOXEL_BITS'(128),
        cmp_low:       VOXEL_BITS'(0),
        cmp_high:      VOXEL_BITS'(128),
        report_ratios: 1'b0
    };

    typedef struct packed {
        logic [VOXEL_BITS-1:0] ref_voxel;
        logic [VOXEL_BITS-1:0] cmp_voxel;
        logic                  end_of_volume;
    } vcms_in_t;

    typedef struct packed {
        logic [CNT_W-1:0] true_pos;
        logic [CNT_W-1:0] true_neg;
        logic [CNT_W-1:0] false_pos;
        logic [CNT_W-1:0] false_neg;
        logic [CNT_W-1:0] total_in_ref;
        logic [CNT_W-1:0] total_in_cmp;
        logic [CNT_W-1:0] total_out_ref;
        logic [CNT_W-1:0] total_out_cmp;
        logic [Q_W-1:0]   precision_q16;
        logic [Q_W-1:0]   recall_q16;
        logic [Q_W-1:0]   fmean_q16;
        logic             ratios_valid;
    } vcms_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] tp;
        logic [CNT_W-1:0] tn;
        logic [CNT_W-1:0] fp;
        logic [CNT_W-1:0] fn;
    } vcms_counts_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } vcms_div_stat_t;

    typedef enum logic [2:0] {
        ST_COUNT,
        ST_LAST,
        ST_PREC,
        ST_REC,
        ST_FMEAN,
        ST_EMIT
    } vcms_state_t;

    typedef enum logic [2:0] {
        D_IDLE,
        D_INIT,
        D_SHIFT,
        D_ROUND,
        D_DONE
    } vcms_dstate_t;

endpackage

FILE: rtl/core/vcms_counter.sv
// Window classification of one voxel pair and the four saturating confusion counters.
module vcms_counter (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  vcms_pkg::vcms_cfg_t    cfg,
    input  vcms_pkg::vcms_in_t     item,
    input  logic                   inc,
    input  logic                   clear,
    output vcms_pkg::vcms_counts_t counts
);
    import vcms_pkg::*;

    vcms_counts_t counts_reg;
    vcms_counts_t counts_next;
    logic         in_a;
    logic         in_b;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    assign in_a = (item.ref_voxel >= cfg.ref_low) && (item.ref_voxel <= cfg.ref_high);
    assign in_b = (item.cmp_voxel >= cfg.cmp_low) && (item.cmp_voxel <= cfg.cmp_high);

    always_comb begin
        counts_next = counts_reg;
        if (clear) begin
            counts_next = '0;
        end else if (inc) begin
            if (in_a && in_b) begin
                counts_next.tp = sat_inc(counts_reg.tp);
            end else if (in_a) begin
                counts_next.fn = sat_inc(counts_reg.fn);
            end else if (in_b) begin
                counts_next.fp = sat_inc(counts_reg.fp);
            end else begin
                counts_next.tn = sat_inc(counts_reg.tn);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg <= '0;
        end else begin
            counts_reg <= counts_next;
        end
    end

    assign counts = counts_reg;

endmodule

FILE: rtl/core/vcms_div.sv
// Restoring fractional divider giving round(num * 2^F / den), one quotient bit per cycle.
module vcms_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [vcms_pkg::DIV_W-1:0]    num,
    input  logic [vcms_pkg::DIV_W-1:0]    den,
    output vcms_pkg::vcms_div_stat_t      stat
);
    import vcms_pkg::*;

    localparam int STEP_W = $clog2(RATIO_FRAC_BITS);

    vcms_dstate_t       state_reg;
    vcms_dstate_t       state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [DIV_W-1:0]   num_reg;
    logic [DIV_W-1:0]   den_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   rem_next;
    logic [Q_W-1:0]     quot_reg;
    logic [Q_W-1:0]     quot_next;
    logic [DIV_W:0]     rem_shift;
    logic [DIV_W:0]     den_ext;
    logic               shift_ge;
    logic               init_ge;
    logic               last_step;

    assign rem_shift = {rem_reg, 1'b0};
    assign den_ext   = {1'b0, den_reg};
    assign shift_ge  = rem_shift >= den_ext;
    assign init_ge   = num_reg >= den_reg;
    assign last_step = step_reg == STEP_W'(RATIO_FRAC_BITS - 1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (start) state_next = D_INIT;
            end
            D_INIT:  state_next = D_SHIFT;
            D_SHIFT: begin
                if (last_step) state_next = D_ROUND;
            end
            D_ROUND: state_next = D_DONE;
            D_DONE: begin
                state_next = start ? D_INIT : D_IDLE;
            end
            default: state_next = D_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        stat.done = (state_reg == D_DONE);
        stat.quot = quot_reg;
    end

    // Datapath.
    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        case (state_reg)
            D_INIT: begin
                rem_next  = init_ge ? num_reg - den_reg : num_reg;
                quot_next = {{(Q_W-1){1'b0}}, init_ge};
                step_next = '0;
            end
            D_SHIFT: begin
                rem_next  = shift_ge ? DIV_W'(rem_shift - den_ext) : DIV_W'(rem_shift);
                quot_next = {quot_reg[Q_W-2:0], shift_ge};
                step_next = step_reg + STEP_W'(1);
            end
            D_ROUND: begin
                if (shift_ge) quot_next = quot_reg + Q_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && (state_reg == D_IDLE || state_reg == D_DONE)) begin
            num_reg <= num;
            den_reg <= den;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
    end

endmodule

FILE: rtl/core/voxel_confusion_matrix_stats.sv
// Top level of the voxel confusion-matrix statistics block: sequencer, registers, result stage.

// Each input item is one pair of co-located voxels, one from a reference volume A and one from
// a compared volume B; a voxel lies inside its shape when its value is within that volume's
// inclusive low..high window (a window with low above high is empty). Every pair adds one to
// the true-positive, true-negative, false-positive or false-negative counter, each of which
// saturates at 2^24. Ordinary pairs stream at one per clock while s_ready is high.
// The pair marked end_of_volume is counted too and then closes the volume: the block drops
// s_ready and emits one result with the four counts, the four totals (each saturating at 2^24)
// and, when report_ratios is set and at least one true positive was seen, precision, recall
// and F-mean = 2TP/(2TP+FP+FN) as unsigned Q1.16 values rounded to nearest with halves up.
// Otherwise the ratios read zero and ratios_valid is clear. The three ratios share a single
// restoring divider that produces one quotient bit per cycle, so the closing item holds the
// input while the ratios are computed, and also while the result register waits for m_ready.
// The counters then clear for the next volume. The result sits in an output register, so
// counting of the next volume goes on while a finished result waits to be taken. Registers
// are written through the cfg port (index 0 to 4: ref_low, ref_high, cmp_low, cmp_high,
// report_ratios); the user must write them only while the block is idle, which the block
// itself does not enforce. Writes to other indices are ignored.
module voxel_confusion_matrix_stats (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vcms_pkg::vcms_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output vcms_pkg::vcms_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vcms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vcms_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import vcms_pkg::*;

    vcms_state_t     state_reg;
    vcms_state_t     state_next;
    vcms_cfg_t       cfg_reg;
    vcms_cfg_t       cfg_next;
    vcms_counts_t    counts;
    vcms_div_stat_t  div_stat;
    vcms_out_t       m_data_reg;
    vcms_out_t       m_data_next;
    logic            m_valid_reg;
    logic [Q_W-1:0]  prec_reg;
    logic [Q_W-1:0]  rec_reg;
    logic [Q_W-1:0]  fmean_reg;
    logic            ratios_valid_reg;

    logic            accept;
    logic            ratios_on;
    logic            div_start;
    logic [DIV_W-1:0] div_num;
    logic [DIV_W-1:0] div_den;
    logic            cnt_clear;
    logic            out_load;
    logic            cap_prec;
    logic            cap_rec;
    logic            cap_fmean;
    logic            ratio_init;
    logic            out_free;

    logic [DIV_W-1:0] tp_w;
    logic [DIV_W-1:0] fp_w;
    logic [DIV_W-1:0] fn_w;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    assign accept    = s_valid && s_ready;
    assign ratios_on = cfg_reg.report_ratios && (counts.tp != '0);
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign tp_w = {{(DIV_W-CNT_W){1'b0}}, counts.tp};
    assign fp_w = {{(DIV_W-CNT_W){1'b0}}, counts.fp};
    assign fn_w = {{(DIV_W-CNT_W){1'b0}}, counts.fn};

    // Configuration registers.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_REF_LOW:       cfg_next.ref_low       = cfg_wdata[VOXEL_BITS-1:0];
                REG_REF_HIGH:      cfg_next.ref_high      = cfg_wdata[VOXEL_BITS-1:0];
                REG_CMP_LOW:       cfg_next.cmp_low       = cfg_wdata[VOXEL_BITS-1:0];
                REG_CMP_HIGH:      cfg_next.cmp_high      = cfg_wdata[VOXEL_BITS-1:0];
                REG_REPORT_RATIOS: cfg_next.report_ratios = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vcms_counter u_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (s_data),
        .inc     (accept),
        .clear   (cnt_clear),
        .counts  (counts)
    );

    vcms_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COUNT: begin
                if (accept && s_data.end_of_volume) state_next = ST_LAST;
            end
            ST_LAST: begin
                state_next = ratios_on ? ST_PREC : ST_EMIT;
            end
            ST_PREC: begin
                if (div_stat.done) state_next = ST_REC;
            end
            ST_REC: begin
                if (div_stat.done) state_next = ST_FMEAN;
            end
            ST_FMEAN: begin
                if (div_stat.done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = ST_COUNT;
            end
            default: state_next = ST_COUNT;
        endcase
    end

    // Sequencer outputs. Each division is launched as the previous one finishes, with the
    // operands selected by the ratio that comes next.
    always_comb begin
        s_ready    = 1'b0;
        div_start  = 1'b0;
        div_num    = tp_w;
        div_den    = tp_w + fp_w;
        cnt_clear  = 1'b0;
        out_load   = 1'b0;
        cap_prec   = 1'b0;
        cap_rec    = 1'b0;
        cap_fmean  = 1'b0;
        ratio_init = 1'b0;
        unique case (state_reg)
            ST_COUNT: s_ready = 1'b1;
            ST_LAST: begin
                ratio_init = 1'b1;
                div_start  = ratios_on;
            end
            ST_PREC: begin
                cap_prec  = div_stat.done;
                div_start = div_stat.done;
                div_den   = tp_w + fn_w;
            end
            ST_REC: begin
                cap_rec   = div_stat.done;
                div_start = div_stat.done;
                div_num   = tp_w << 1;
                div_den   = (tp_w << 1) + fp_w + fn_w;
            end
            ST_FMEAN: cap_fmean = div_stat.done;
            ST_EMIT: begin
                out_load  = out_free;
                cnt_clear = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Ratio holding registers; cleared at the start of each closing pass.
    always_ff @(posedge aclk) begin
        if (ratio_init) begin
            prec_reg         <= '0;
            rec_reg          <= '0;
            fmean_reg        <= '0;
            ratios_valid_reg <= ratios_on;
        end else begin
            if (cap_prec)  prec_reg  <= div_stat.quot;
            if (cap_rec)   rec_reg   <= div_stat.quot;
            if (cap_fmean) fmean_reg <= div_stat.quot;
        end
    end

    // Result assembly.
    always_comb begin
        m_data_next.true_pos      = counts.tp;
        m_data_next.true_neg      = counts.tn;
        m_data_next.false_pos     = counts.fp;
        m_data_next.false_neg     = counts.fn;
        m_data_next.total_in_ref  = sat_add(counts.tp, counts.fn);
        m_data_next.total_in_cmp  = sat_add(counts.tp, counts.fp);
        m_data_next.total_out_ref = sat_add(counts.tn, counts.fp);
        m_data_next.total_out_cmp = sat_add(counts.tn, counts.fn);
        m_data_next.precision_q16 = prec_reg;
        m_data_next.recall_q16    = rec_reg;
        m_data_next.fmean_q16     = fmean_reg;
        m_data_next.ratios_valid  = ratios_valid_reg;
    end

    // Output register: holds a finished result until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the voxel confusion-matrix statistics block.
module tb_top;
    import vcms_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 4;
    // The closing item of a volume holds the input while the divider runs.
    localparam int SETTLE_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 75;
    localparam int HOLD_AFTER_ITEMS = 300;
    localparam int HOLD_MIN_QUEUED  = 40;
    localparam int HOLD_CYCLES      = 400;
    localparam int RX_MODE_SPAN     = 64;

    // Indices above the last register must be accepted and ignored.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = CFG_IDX_W'(7);

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    vcms_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    vcms_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Voxel pairs waiting to be offered, and the statistics expected back, oldest first.
    vcms_in_t  pair_q[$];
    vcms_out_t stats_q[$];

    // The testbench's own copy of the registers and of the four confusion counters.
    vcms_cfg_t        cfg_shadow = CFG_RESET;
    logic [CNT_W-1:0] tp_n = '0;
    logic [CNT_W-1:0] tn_n = '0;
    logic [CNT_W-1:0] fp_n = '0;
    logic [CNT_W-1:0] fn_n = '0;

    int       fail_cnt        = 0;
    int       pairs_taken     = 0;
    int       idle_cycles     = 0;
    bit       pair_taken_last = 1'b0;
    int       burst_left      = 0;
    int       gap_left        = 0;
    int       rx_cycle        = 0;
    int       hold_left       = 0;
    bit       hold_done       = 1'b0;
    rx_mode_t rx_mode         = RX_ALWAYS;

    voxel_confusion_matrix_stats i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A counter sticks once it has reached its ceiling of 2^COUNT_LOG2.
    function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + CNT_W'(1);
    endfunction

    // The emitted totals saturate at the same ceiling as the counters.
    function automatic logic [CNT_W-1:0] capped_sum(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    // num/den as an unsigned Q1.16 fraction, rounded to nearest with halves going up.
    // The quotient is built one bit at a time, as a restoring divider would.
    function automatic logic [Q_W-1:0] q16_ratio(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int              i;
        if (den == 0) begin
            return '0;
        end
        q = (num >= den) ? 64'd1 : 64'd0;
        r = num - q * den;
        for (i = 0; i < RATIO_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= den) begin
            q = q + 64'd1;
        end
        return Q_W'(q);
    endfunction

    // Counts one accepted voxel pair; the closing pair of a volume also yields the statistics
    // of the whole volume, after which the counters start again from zero.
    function automatic void tally_pair(vcms_in_t p);
        logic            in_a;
        logic            in_b;
        vcms_out_t       r;
        longint unsigned tp;
        longint unsigned fp;
        longint unsigned fn;
        in_a = (p.ref_voxel >= cfg_shadow.ref_low) && (p.ref_voxel <= cfg_shadow.ref_high);
        in_b = (p.cmp_voxel >= cfg_shadow.cmp_low) && (p.cmp_voxel <= cfg_shadow.cmp_high);
        if (in_a && in_b) begin
            tp_n = count_up(tp_n);
        end else if (in_a) begin
            fn_n = count_up(fn_n);
        end else if (in_b) begin
            fp_n = count_up(fp_n);
        end else begin
            tn_n = count_up(tn_n);
        end
        if (!p.end_of_volume) begin
            return;
        end
        r               = '0;
        r.true_pos      = tp_n;
        r.true_neg      = tn_n;
        r.false_pos     = fp_n;
        r.false_neg     = fn_n;
        r.total_in_ref  = capped_sum(tp_n, fn_n);
        r.total_in_cmp  = capped_sum(tp_n, fp_n);
        r.total_out_ref = capped_sum(tn_n, fp_n);
        r.total_out_cmp = capped_sum(tn_n, fn_n);
        // Without a true positive, or with report_ratios clear, all ratios stay at zero.
        if (cfg_shadow.report_ratios && tp_n != '0) begin
            tp              = 64'(tp_n);
            fp              = 64'(fp_n);
            fn              = 64'(fn_n);
            r.precision_q16 = q16_ratio(tp, tp + fp);
            r.recall_q16    = q16_ratio(tp, tp + fn);
            r.fmean_q16     = q16_ratio(64'd2 * tp, 64'd2 * tp + fp + fn);
            r.ratios_valid  = 1'b1;
        end
        stats_q = {stats_q, r};
        tp_n = '0;
        tn_n = '0;
        fp_n = '0;
        fn_n = '0;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void check_stats(vcms_out_t got);
        vcms_out_t want;
        if (stats_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            fail_cnt++;
            return;
        end
        want = stats_q.pop_front();
        check_field("true_pos", 64'(want.true_pos), 64'(got.true_pos));
        check_field("true_neg", 64'(want.true_neg), 64'(got.true_neg));
        check_field("false_pos", 64'(want.false_pos), 64'(got.false_pos));
        check_field("false_neg", 64'(want.false_neg), 64'(got.false_neg));
        check_field("total_in_ref", 64'(want.total_in_ref), 64'(got.total_in_ref));
        check_field("total_in_cmp", 64'(want.total_in_cmp), 64'(got.total_in_cmp));
        check_field("total_out_ref", 64'(want.total_out_ref), 64'(got.total_out_ref));
        check_field("total_out_cmp", 64'(want.total_out_cmp), 64'(got.total_out_cmp));
        check_field("precision_q16", 64'(want.precision_q16), 64'(got.precision_q16));
        check_field("recall_q16", 64'(want.recall_q16), 64'(got.recall_q16));
        check_field("fmean_q16", 64'(want.fmean_q16), 64'(got.fmean_q16));
        check_field("ratios_valid", 64'(want.ratios_valid), 64'(got.ratios_valid));
    endfunction

    // Monitor: every handshake is sampled at the rising edge. The watchdog ends the run when
    // no item has moved on any channel for too long.
    always @(posedge aclk) begin
        pair_taken_last <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tally_pair(s_data);
                pairs_taken <= pairs_taken + 1;
            end
            if (m_valid && m_ready) begin
                check_stats(m_data);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver, both moving on the falling edge
    // ------------------------------------------------------------------

    // The sender works in bursts of random length separated by random gaps; a burst with no
    // gap after it runs straight into the next, which gives stretches of back-to-back items.
    always @(negedge aclk) begin
        if (s_valid && !pair_taken_last) begin
            // The item on offer has not been taken yet, so it stays as it is.
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (pair_q.size() != 0) begin
            s_data  <= pair_q.pop_front();
            s_valid <= 1'b1;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // The receiver changes its stall pattern every so often. Once, well into the run and while
    // plenty of pairs are still waiting to be sent, it refuses results for a long stretch so
    // that the result register fills and the block has to hold back its input while the
    // sender keeps offering.
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % RX_MODE_SPAN == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        end
        if (!hold_done && pairs_taken >= HOLD_AFTER_ITEMS && pair_q.size() >= HOLD_MIN_QUEUED) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   m_ready <= 1'b1;
                RX_HALF:     m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_ready <= ((rx_cycle % 8) < 5);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void queue_pair(logic [VOXEL_BITS-1:0] a, logic [VOXEL_BITS-1:0] b,
                                       logic last);
        vcms_in_t p;
        p.ref_voxel     = a;
        p.cmp_voxel     = b;
        p.end_of_volume = last;
        pair_q = {pair_q, p};
    endfunction

    // Voxel values cluster on and just beside the window edges, where the comparisons flip.
    function automatic logic [VOXEL_BITS-1:0] pick_voxel(logic [VOXEL_BITS-1:0] lo,
                                                         logic [VOXEL_BITS-1:0] hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            2:       return lo - VOXEL_BITS'(1);
            3:       return hi + VOXEL_BITS'(1);
            default: return VOXEL_BITS'($urandom);
        endcase
    endfunction

    // Mostly a proper window; now and then an arbitrary pair, which may well be empty.
    function automatic void random_window(output logic [VOXEL_BITS-1:0] lo,
                                          output logic [VOXEL_BITS-1:0] hi);
        lo = VOXEL_BITS'($urandom_range(0, 255));
        hi = ($urandom_range(0, 4) == 0) ? VOXEL_BITS'($urandom_range(0, 255))
                                         : VOXEL_BITS'($urandom_range(lo, 255));
    endfunction

    // Registers are written only while the block is idle; the shadow copy follows the write
    // at the edge where it is accepted.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_REF_LOW:       cfg_shadow.ref_low       = val;
            REG_REF_HIGH:      cfg_shadow.ref_high      = val;
            REG_CMP_LOW:       cfg_shadow.cmp_low       = val;
            REG_CMP_HIGH:      cfg_shadow.cmp_high      = val;
            REG_REPORT_RATIOS: cfg_shadow.report_ratios = val[0];
            default:           ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every pair has been taken and every result has come back, then gives the
    // divider time to finish before anything else happens.
    task automatic drain_and_settle();
        while (pair_q.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (stats_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int                    ph;
        int                    n;
        int                    len;
        int                    k;
        int                    idx;
        logic [VOXEL_BITS-1:0] rl;
        logic [VOXEL_BITS-1:0] rh;
        logic [VOXEL_BITS-1:0] cl;
        logic [VOXEL_BITS-1:0] ch;
        logic                  ratios_on;
        logic [6:0]            pad;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset windows 0..128 with ratios off: one pair of each kind, the window edges
        // included, closed by the false positive.
        queue_pair(8'd0, 8'd0, 1'b0);
        queue_pair(8'd255, 8'd255, 1'b0);
        queue_pair(8'd128, 8'd129, 1'b0);
        queue_pair(8'd129, 8'd128, 1'b1);
        drain_and_settle();

        // Writes beyond the last register must leave everything unchanged.
        for (idx = REG_FIRST_UNUSED; idx <= REG_LAST_UNUSED; idx++) begin
            cfg_write(CFG_IDX_W'(idx), 8'hFF);
        end
        cfg_write(REG_REPORT_RATIOS, 8'h01);

        // A single true positive gives ratios of exactly one; a volume with no true positive
        // leaves them at zero; then a mixed volume with fractional ratios.
        queue_pair(8'd128, 8'd128, 1'b1);
        queue_pair(8'd200, 8'd200, 1'b1);
        queue_pair(8'd0, 8'd200, 1'b0);
        queue_pair(8'd200, 8'd0, 1'b0);
        queue_pair(8'd5, 8'd5, 1'b0);
        queue_pair(8'd7, 8'd7, 1'b0);
        queue_pair(8'd9, 8'd250, 1'b0);
        queue_pair(8'd130, 8'd131, 1'b1);
        drain_and_settle();

        // An empty reference window, with low above high, and a one-value top window.
        cfg_write(REG_REF_LOW, 8'd200);
        cfg_write(REG_REF_HIGH, 8'd100);
        cfg_write(REG_CMP_LOW, 8'd255);
        cfg_write(REG_CMP_HIGH, 8'd255);
        queue_pair(8'd150, 8'd255, 1'b0);
        queue_pair(8'd100, 8'd255, 1'b0);
        queue_pair(8'd200, 8'd0, 1'b1);
        drain_and_settle();

        // One-value windows at both ends of the range; only bit 0 of the enable write counts.
        cfg_write(REG_REF_LOW, 8'd255);
        cfg_write(REG_REF_HIGH, 8'd255);
        cfg_write(REG_CMP_LOW, 8'd0);
        cfg_write(REG_CMP_HIGH, 8'd0);
        cfg_write(REG_REPORT_RATIOS, 8'hFF);
        queue_pair(8'd255, 8'd0, 1'b0);
        queue_pair(8'd254, 8'd0, 1'b0);
        queue_pair(8'd255, 8'd1, 1'b1);
        drain_and_settle();

        // Random part: each phase picks new windows, then streams volumes of random length,
        // mostly short so that the closing items and their results come often.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    rl = 8'd0;
                    rh = 8'd255;
                    cl = 8'd0;
                    ch = 8'd255;
                    ratios_on = 1'b1;
                end
                1: begin
                    random_window(rl, rh);
                    cl = 8'd255;
                    ch = 8'd0;
                    ratios_on = 1'b1;
                end
                default: begin
                    random_window(rl, rh);
                    random_window(cl, ch);
                    ratios_on = ($urandom_range(0, 3) != 0);
                end
            endcase
            pad = 7'($urandom);
            cfg_write(REG_REF_LOW, rl);
            cfg_write(REG_REF_HIGH, rh);
            cfg_write(REG_CMP_LOW, cl);
            cfg_write(REG_CMP_HIGH, ch);
            cfg_write(REG_REPORT_RATIOS, {pad, ratios_on});

            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    queue_pair(pick_voxel(rl, rh), pick_voxel(cl, ch), k == len - 1);
                end
                n += len;
            end
            drain_and_settle();
        end

        if (fail_cnt == 0 && stats_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
